FILE: rtl/core/rtti_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and digit decode for the radix text parser.
// No dependencies; imported by every module of the block.
package rtti_pkg;

    localparam int AccWidth   = 128;
    localparam int HalfWidth  = 64;
    localparam int RadixWidth = 6;
    localparam int CharWidth  = 8;
    localparam int DigitWidth = 7;

    typedef logic [AccWidth-1:0]   t_acc;
    typedef logic [HalfWidth-1:0]  t_half;
    typedef logic [RadixWidth-1:0] t_radix;
    typedef logic [CharWidth-1:0]  t_char;
    typedef logic [DigitWidth-1:0] t_digit;

    // configuration register indexes
    typedef enum logic {
        CfgRadix  = 1'b0,
        CfgSigned = 1'b1
    } t_cfg_index;

    localparam t_radix RadixReset  = 6'd10;
    localparam logic   SignedReset = 1'b1;

    localparam t_char CharMinus  = 8'h2D;  // '-'
    localparam t_char CharZero   = 8'h30;  // '0'
    localparam t_char CharNine   = 8'h39;
    localparam t_char CharUpperA = 8'h41;  // 'A'
    localparam t_char CharUpperZ = 8'h5A;
    localparam t_char CharLowerA = 8'h61;
    localparam t_char CharLowerZ = 8'h7A;
    localparam t_char LetterBase = 8'd10;

    // marks a byte that is no digit; above every 6-bit radix
    localparam t_digit DigitNone = 7'd64;

    // per-string state
    typedef struct packed {
        logic char_seen;
        logic digits_seen;
        logic negative;
        logic error;
    } t_str_state;

    typedef struct packed {
        t_half lo;
        t_half hi;
        logic  fail;
    } t_result;

    function automatic t_digit digit_of(input t_char ch);
        t_char v;
        v = t_char'(DigitNone);
        if (ch >= CharZero && ch <= CharNine) begin
            v = ch - CharZero;
        end else if (ch >= CharUpperA && ch <= CharUpperZ) begin
            v = ch - CharUpperA + LetterBase;
        end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
            v = ch - CharLowerA + LetterBase;
        end
        return v[DigitWidth-1:0];
    endfunction

endpackage

FILE: rtl/core/rtti_mul_add.sv
`timescale 1ns / 1ps
// Accumulator step: acc * radix + digit over 128 bits with overflow flag.
// Depends on rtti_pkg.
module rtti_mul_add (
    input  rtti_pkg::t_acc   i_acc,
    input  rtti_pkg::t_radix i_radix,
    input  rtti_pkg::t_radix i_digit,
    output rtti_pkg::t_acc   o_sum,
    output logic             o_ovf
);
    import rtti_pkg::*;

    localparam int ProdWidth = AccWidth + RadixWidth;

    logic [ProdWidth-1:0] w_prod;
    logic [ProdWidth-1:0] w_total;

    // 128 x 6 product; cannot wrap within ProdWidth even with the digit added
    assign w_prod  = {{RadixWidth{1'b0}}, i_acc} * {{AccWidth{1'b0}}, i_radix};
    assign w_total = w_prod + {{AccWidth{1'b0}}, i_digit};
    assign o_sum   = w_total[AccWidth-1:0];
    assign o_ovf   = |w_total[ProdWidth-1:AccWidth];

endmodule

FILE: rtl/core/rtti_finish.sv
`timescale 1ns / 1ps
// End-of-string evaluation: range check, sign application and fail zeroing.
// Depends on rtti_pkg.
module rtti_finish (
    input  rtti_pkg::t_acc       i_acc,
    input  rtti_pkg::t_str_state i_st,
    input  logic                 i_signed_mode,
    output rtti_pkg::t_result    o_result
);
    import rtti_pkg::*;

    logic w_fail;
    logic w_range_bad;
    t_acc w_neg;
    t_acc w_val;

    assign w_neg = ~i_acc + t_acc'(1);

    always_comb begin
        w_range_bad = 1'b0;
        if (i_signed_mode || i_st.negative) begin
            if (i_st.negative) begin
                // magnitude 2^127 is the int128 minimum and allowed
                w_range_bad = i_acc[AccWidth-1] && (|i_acc[AccWidth-2:0]);
            end else begin
                w_range_bad = i_acc[AccWidth-1];
            end
        end
        w_fail = i_st.error || !i_st.digits_seen || w_range_bad;
        if (w_fail) begin
            w_val = '0;
        end else if (i_st.negative) begin
            w_val = w_neg;
        end else begin
            w_val = i_acc;
        end
        o_result.lo   = w_val[HalfWidth-1:0];
        o_result.hi   = w_val[AccWidth-1:HalfWidth];
        o_result.fail = w_fail;
    end

endmodule

FILE: rtl/core/radix_text_to_int128_parser.sv
`timescale 1ns / 1ps
// Radix text to int128 parser, top level. Uses rtti_pkg, rtti_mul_add, rtti_finish.
// Result path: an accepted end beat is held in the input register, then evaluated into the output register.
// Throughput: one beat per cycle; the 128 x 6 multiply-add updates the accumulator
// on the edge after each character beat is registered. The input stalls only while
// an end beat waits behind a stalled result. Reset (synchronous, active low): radix 10,
// signed mode on, string state clear.
module radix_text_to_int128_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  rtti_pkg::t_radix     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rtti_pkg::t_char      i_char_code,
    input  logic                 i_end_of_text,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rtti_pkg::t_half      o_value_low,
    output rtti_pkg::t_half      o_value_high,
    output logic                 o_parse_failed
);
    import rtti_pkg::*;

    // configuration
    t_radix     r_radix;
    logic       r_signed;

    // input register
    logic       r_s1_valid;
    t_char      r_s1_char;
    logic       r_s1_end;

    // string state
    t_acc       r_acc, n_acc;
    t_str_state r_st, n_st;

    // output register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_s1_go;
    logic       w_in_acc;
    t_digit     w_digit;
    t_acc       w_sum;
    logic       w_ovf;
    t_result    w_result;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_go    = r_s1_valid && (!r_s1_end || w_out_free);
    assign o_in_stall = r_s1_valid && !w_s1_go;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_digit = digit_of(r_s1_char);

    rtti_mul_add u_mul_add (
        .i_acc   (r_acc),
        .i_radix (r_radix),
        .i_digit (w_digit[RadixWidth-1:0]),
        .o_sum   (w_sum),
        .o_ovf   (w_ovf)
    );

    rtti_finish u_finish (
        .i_acc         (r_acc),
        .i_st          (r_st),
        .i_signed_mode (r_signed),
        .o_result      (w_result)
    );

    // character beat processing; an end beat clears the string state
    always_comb begin
        n_acc = r_acc;
        n_st  = r_st;
        if (w_s1_go) begin
            if (r_s1_end) begin
                n_acc = '0;
                n_st  = '0;
            end else begin
                n_st.char_seen = 1'b1;
                if (!r_st.error) begin
                    if (!r_st.char_seen && r_s1_char == CharMinus && r_signed) begin
                        n_st.negative = 1'b1;
                    end else if (r_radix < t_radix'(2)
                                 || w_digit >= {1'b0, r_radix}) begin
                        n_st.error = 1'b1;
                    end else begin
                        n_acc          = w_sum;
                        n_st.digits_seen = 1'b1;
                        if (w_ovf) begin
                            n_st.error = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RadixReset;
            r_signed <= SignedReset;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CfgRadix:  r_radix  <= i_cfg_wdata;
                CfgSigned: r_signed <= i_cfg_wdata[0];
                default:   r_radix  <= r_radix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_acc       <= '0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            r_acc <= n_acc;
            r_st  <= n_st;
            if (w_s1_go && r_s1_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_char <= i_char_code;
            r_s1_end  <= i_end_of_text;
        end
        if (w_s1_go && r_s1_end) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_low    = r_out.lo;
    assign o_value_high   = r_out.hi;
    assign o_parse_failed = r_out.fail;

endmodule

FILE: rtl/core/rtti_checker.sv
`timescale 1ns / 1ps
// Port-level checks for radix_text_to_int128_parser, bound to the top level.
// Depends on rtti_pkg.
module rtti_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input rtti_pkg::t_half  o_value_low,
    input rtti_pkg::t_half  o_value_high,
    input logic             o_parse_failed
);
    import rtti_pkg::*;

    // a held result beat stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_value_low) && $stable(o_value_high) && $stable(o_parse_failed))
        else $error("result payload changed while stalled");

    // a failed parse reports a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parse_failed |-> o_value_low == '0 && o_value_high == '0)
        else $error("failed parse with nonzero value");

    // input backpressure only comes from a stalled pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind radix_text_to_int128_parser rtti_checker u_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for radix_text_to_int128_parser: directed and random text streams, checked
// against an in-bench 128-bit accumulator model. Depends on rtti_pkg and the parser RTL.
module tb_top;
    import rtti_pkg::*;

    localparam int   CycleLimit    = 400000;
    localparam t_acc Int128MinMag  = t_acc'(1) << (AccWidth - 1);

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    t_cfg_index i_cfg_index;
    t_radix     i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_char      i_char_code;
    logic       i_end_of_text;
    logic       o_out_valid;
    logic       i_out_stall;
    t_half      o_value_low;
    t_half      o_value_high;
    logic       o_parse_failed;

    radix_text_to_int128_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value_low    (o_value_low),
        .o_value_high   (o_value_high),
        .o_parse_failed (o_parse_failed)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // parser model state
    t_radix  cfg_radix;
    logic    cfg_signed;
    t_acc    magnitude;
    logic    text_started;
    logic    digit_taken;
    logic    text_negative;
    logic    text_error;
    t_result pending_results[$];

    int send_idle_pct;
    int stall_pct;
    int beats_sent;
    int mismatch_count;
    int cycle_count;

    function automatic void clear_text();
        magnitude     = '0;
        text_started  = 1'b0;
        digit_taken   = 1'b0;
        text_negative = 1'b0;
        text_error    = 1'b0;
    endfunction

    function automatic t_digit char_digit(t_char ch);
        if (ch >= CharZero && ch <= CharNine) begin
            return t_digit'(ch - CharZero);
        end else if (ch >= CharUpperA && ch <= CharUpperZ) begin
            return t_digit'(ch - CharUpperA + LetterBase);
        end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
            return t_digit'(ch - CharLowerA + LetterBase);
        end
        return DigitNone;
    endfunction

    function automatic void predict_char(t_char ch);
        logic                         was_first;
        t_digit                       dv;
        logic [AccWidth+RadixWidth:0] prod;
        was_first    = !text_started;
        text_started = 1'b1;
        if (text_error) return;
        if (was_first && ch == CharMinus && cfg_signed) begin
            text_negative = 1'b1;
            return;
        end
        dv = char_digit(ch);
        if (cfg_radix < 2 || dv >= cfg_radix) begin
            text_error = 1'b1;
            return;
        end
        prod = magnitude * cfg_radix + dv;
        if (prod[AccWidth +: RadixWidth+1] != 0) text_error = 1'b1;
        magnitude   = prod[AccWidth-1:0];
        digit_taken = 1'b1;
    endfunction

    function automatic void predict_end();
        t_result res;
        logic    bad;
        t_acc    val;
        bad = text_error || !digit_taken;
        val = magnitude;
        // the minus sign alone also forces the int128 range check
        if (!bad && (cfg_signed || text_negative)) begin
            if (text_negative) begin
                bad = val > Int128MinMag;
            end else begin
                bad = val >= Int128MinMag;
            end
            if (!bad && text_negative) val = -val;
        end
        if (bad) val = '0;
        res.lo   = val[HalfWidth-1:0];
        res.hi   = val[AccWidth-1:HalfWidth];
        res.fail = bad;
        pending_results.push_back(res);
        clear_text();
    endfunction

    task automatic flag_mismatch(input string what, input t_half want, input t_half got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, parse_failed", '0, t_half'(o_parse_failed));
            end else begin
                want = pending_results.pop_front();
                if (o_value_low !== want.lo) flag_mismatch("value_low", want.lo, o_value_low);
                if (o_value_high !== want.hi) flag_mismatch("value_high", want.hi, o_value_high);
                if (o_parse_failed !== want.fail) begin
                    flag_mismatch("parse_failed", t_half'(want.fail), t_half'(o_parse_failed));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("radix_text_to_int128_parser: mismatch");
            $finish;
        end
    end

    // valid stays high after a beat so back-to-back beats need no toggle
    task automatic send_beat(input t_char ch, input logic eot);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_char_code   <= ch;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        if (eot) begin
            predict_end();
        end else begin
            predict_char(ch);
        end
    endtask

    task automatic send_end();
        send_beat(t_char'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(t_char'(s[i]), 1'b0);
        send_end();
    endtask

    task automatic send_text(input t_char txt[$]);
        foreach (txt[i]) send_beat(txt[i], 1'b0);
        send_end();
    endtask

    // drop valid, wait for all results, then let the accumulator pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input t_radix data);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CfgRadix) begin
            cfg_radix = data;
        end else begin
            cfg_signed = data[0];
        end
    endtask

    function automatic t_char digit_char(int d);
        if (d < 10) return t_char'(CharZero + d);
        return t_char'(($urandom_range(1) ? CharUpperA : CharLowerA) + d - 10);
    endfunction

    function automatic logic [AccWidth+7:0] pick_value();
        logic [AccWidth+7:0] big;
        int                  off;
        big = {$urandom, $urandom, $urandom, $urandom, $urandom};
        off = $urandom_range(6);
        case ($urandom_range(5))
            0: return 136'($urandom_range(1000));
            1: return 136'(big[AccWidth-1:0] >> $urandom_range(AccWidth - 1));
            2: return (136'd1 << 127) + 136'(off) - 136'd3;
            3: return (136'd1 << 128) + 136'(off) - 136'd3;
            4: return (136'd1 << 64) + 136'(off) - 136'd3;
            default: return big >> $urandom_range(8);
        endcase
    endfunction

    function automatic void build_text(ref t_char txt[$]);
        logic [AccWidth+7:0] rest;
        int unsigned         r;
        int                  kind;
        txt.delete();
        r    = 32'(cfg_radix);
        kind = $urandom_range(99);
        if (kind < 14) begin
            // broken text: stray bytes, misplaced minus signs
            repeat ($urandom_range(8)) begin
                case ($urandom_range(3))
                    0: txt.push_back(t_char'($urandom_range(255)));
                    1: txt.push_back(CharMinus);
                    default: txt.push_back(digit_char($urandom_range(35)));
                endcase
            end
        end else if (r < 2 || r > 36) begin
            repeat ($urandom_range(25)) txt.push_back(digit_char($urandom_range(35)));
            if ($urandom_range(1)) txt.push_front(CharMinus);
        end else begin
            rest = pick_value();
            do begin
                txt.push_front(digit_char(int'(rest % r)));
                rest = rest / r;
            end while (rest != 0);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) txt.push_front(CharZero);
            end
            if ((cfg_signed || kind < 18) && $urandom_range(1)) txt.push_front(CharMinus);
        end
    endfunction

    task automatic test_special_strings();
        send_end();                     // empty
        send_str("-");                  // lone minus
        send_str("-7");
        send_str("4-");                 // minus after a digit
        send_beat(8'h00, 1'b0);
        send_end();
        send_beat(8'hFF, 1'b0);
        send_end();
        send_str("a");                  // digit equal to radix 10
    endtask

    task automatic test_unsigned_minus();
        write_cfg(CfgSigned, 6'd0);
        send_str("-1");
        send_str("9");
        write_cfg(CfgSigned, 6'd1);
    endtask

    task automatic test_radix_extremes();
        write_cfg(CfgRadix, 6'd36);
        send_str("Zz");
        write_cfg(CfgRadix, 6'd63);
        send_str("z");
        write_cfg(CfgRadix, 6'd1);
        send_str("0");
        write_cfg(CfgRadix, 6'd0);
        send_str("-1");
        write_cfg(CfgRadix, 6'd10);
    endtask

    // minus taken in signed mode, then mode dropped before the end beat
    task automatic test_sign_mode_switch();
        send_beat(CharMinus, 1'b0);
        write_cfg(CfgSigned, 6'd0);
        send_beat(CharZero + 8'd3, 1'b0);
        send_end();
        write_cfg(CfgSigned, 6'd1);
    endtask

    task automatic pick_setting();
        t_radix r;
        case ($urandom_range(11))
            0: r = 6'd0;
            1: r = 6'd1;
            2: r = 6'd63;
            3: r = t_radix'($urandom_range(37, 63));
            4: r = 6'd2;
            5: r = 6'd36;
            default: r = t_radix'($urandom_range(2, 36));
        endcase
        write_cfg(CfgRadix, r);
        write_cfg(CfgSigned, t_radix'(($urandom_range(31) << 1) | $urandom_range(1)));
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_p);
        t_char txt[$];
        int    first_beat;
        int    texts;
        send_idle_pct = gap_pct;
        stall_pct     = stall_p;
        first_beat    = beats_sent;
        texts         = 0;
        while (beats_sent - first_beat < 140 || texts < 5) begin
            if (texts % 5 == 0) pick_setting();
            build_text(txt);
            send_text(txt);
            texts++;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= CfgRadix;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_char_code    <= '0;
        i_end_of_text  <= 1'b0;
        i_out_stall    <= 1'b0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        beats_sent     = 0;
        mismatch_count = 0;
        cfg_radix      = RadixReset;
        cfg_signed     = SignedReset;
        clear_text();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_strings();
        test_unsigned_minus();
        test_radix_extremes();
        test_sign_mode_switch();
        test_random_traffic(0, 0);
        test_random_traffic(84, 0);
        test_random_traffic(0, 84);
        test_random_traffic(38, 38);

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("radix_text_to_int128_parser: match");
        end else begin
            $display("radix_text_to_int128_parser: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/rtti_pkg.sv
rtl/core/rtti_mul_add.sv
rtl/core/rtti_finish.sv
rtl/core/radix_text_to_int128_parser.sv
rtl/core/rtti_checker.sv
verif/tb_top.sv
